// ===== hdl/ssd_pkg.sv =====
package ssd_pkg;

   // decoder phases
   localparam logic [1:0] PH_HEADER = 2'd0;
   localparam logic [1:0] PH_XSTART = 2'd1;
   localparam logic [1:0] PH_PIXELS = 2'd2;
   localparam logic [1:0] PH_DONE   = 2'd3;

   // status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_PREMATURE = 2'd1;
   localparam logic [1:0] ST_BOUNDS   = 2'd2;

   // span header fields
   localparam logic [7:0] LAST_MARK = 8'h80;
   localparam logic [6:0] LEN_MASK  = 7'h7F;

   // configuration register indexes
   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   // configuration reset values
   localparam logic [9:0] WIDTH_RESET  = 10'd64;
   localparam logic [9:0] HEIGHT_RESET = 10'd64;

   typedef struct packed {
      logic [1:0] phase;
      logic       last_span;
      logic [6:0] span_remaining;
      logic [9:0] column;
      logic [9:0] row_index;
      logic [1:0] error_code;
   } state_type;

   typedef struct packed {
      logic       pixel_valid;
      logic [9:0] pixel_x;
      logic [9:0] pixel_row;
      logic [7:0] pixel_value;
      logic       row_done;
      logic       image_done;
      logic [1:0] status;
   } result_type;

endpackage

// ===== hdl/ssd_step.sv =====
module ssd_step (
   input  ssd_pkg::state_type  cur_state,
   input  logic [7:0]          data_byte,
   input  logic                chunk_end,
   input  logic [9:0]          image_width,
   input  logic [9:0]          image_height,
   output ssd_pkg::state_type  nxt_state,
   output ssd_pkg::result_type result
);

   logic       close_span;
   logic [9:0] span_end;
   logic [9:0] row_inc;
   logic [6:0] rem_dec;

   assign span_end = {2'b00, data_byte} + {3'b000, cur_state.span_remaining};
   assign row_inc  = cur_state.row_index + 10'd1;
   assign rem_dec  = cur_state.span_remaining - 7'd1;

   // one byte of span data against the current decoder state
   always_comb begin
      nxt_state  = cur_state;
      result     = '0;
      close_span = 1'b0;
      if (cur_state.error_code == ssd_pkg::ST_OK && cur_state.phase != ssd_pkg::PH_DONE) begin
         unique case (cur_state.phase)
            ssd_pkg::PH_HEADER: begin
               nxt_state.last_span      = (data_byte & ssd_pkg::LAST_MARK) != 8'h00;
               nxt_state.span_remaining = data_byte[6:0] & ssd_pkg::LEN_MASK;
               nxt_state.phase          = ssd_pkg::PH_XSTART;
            end
            ssd_pkg::PH_XSTART: begin
               nxt_state.column = {2'b00, data_byte};
               if (span_end > image_width) begin
                  nxt_state.error_code = ssd_pkg::ST_BOUNDS;
               end else if (cur_state.span_remaining == 7'd0) begin
                  close_span = 1'b1;
               end else begin
                  nxt_state.phase = ssd_pkg::PH_PIXELS;
               end
            end
            default: begin
               result.pixel_valid       = 1'b1;
               result.pixel_x           = cur_state.column;
               result.pixel_row         = cur_state.row_index;
               result.pixel_value       = data_byte;
               nxt_state.column         = cur_state.column + 10'd1;
               nxt_state.span_remaining = rem_dec;
               close_span               = (rem_dec == 7'd0);
            end
         endcase

         // end of span, maybe end of row and image
         if (close_span) begin
            nxt_state.phase = ssd_pkg::PH_HEADER;
            if (cur_state.last_span) begin
               result.row_done     = 1'b1;
               nxt_state.row_index = row_inc;
               if (row_inc >= image_height || row_inc == 10'd0) begin
                  result.image_done = 1'b1;
                  nxt_state.phase   = ssd_pkg::PH_DONE;
               end
            end
         end

         // data ran out before the image completed
         if (nxt_state.error_code == ssd_pkg::ST_OK && chunk_end &&
             nxt_state.phase != ssd_pkg::PH_DONE) begin
            nxt_state.error_code = ssd_pkg::ST_PREMATURE;
         end
      end
      result.status = nxt_state.error_code;
   end

endmodule

// ===== hdl/sprite_span_decoder_top.sv =====
// channel  ports                         direction  word
// req      req_valid/req_ready           in         data_byte, chunk_end
// rsp      rsp_valid/rsp_ready           out        pixel write, row/image done, status
// csr      csr_valid/csr_ready           in         register index, 10-bit write data
//
// one byte per cycle unless rsp_ready stalls the result register; a byte passes
// through the input register and then the result register.
// the decode state lives in one register updated by the step logic for each byte.
// reset (synchronous) returns the state to the header phase, clears status
// and both valid flags, and sets width and height to 64.
// a stalled result holds in the output register while one more byte waits
// in the input register; req_ready drops only when both are full.
module sprite_span_decoder_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_chunk_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_pixel_valid,
   output logic [9:0] rsp_pixel_x,
   output logic [9:0] rsp_pixel_row,
   output logic [7:0] rsp_pixel_value,
   output logic       rsp_row_done,
   output logic       rsp_image_done,
   output logic [1:0] rsp_status,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  logic [9:0] csr_wdata
);

   logic                in_valid_ff;
   logic [7:0]          in_data_ff;
   logic                in_end_ff;
   logic                out_valid_ff;
   ssd_pkg::result_type out_word_ff;
   ssd_pkg::state_type  state_ff;
   ssd_pkg::state_type  state_in;
   ssd_pkg::result_type result;
   logic [9:0]          width_ff;
   logic [9:0]          height_ff;
   logic                step_fire;

   assign step_fire = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step_fire;
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= ssd_pkg::WIDTH_RESET;
         height_ff <= ssd_pkg::HEIGHT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            ssd_pkg::CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            ssd_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data_byte;
         in_end_ff  <= req_chunk_end;
      end
   end

   ssd_step u_step (
      .cur_state    (state_ff),
      .data_byte    (in_data_ff),
      .chunk_end    (in_end_ff),
      .image_width  (width_ff),
      .image_height (height_ff),
      .nxt_state    (state_in),
      .result       (result)
   );

   // decode state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase          <= ssd_pkg::PH_HEADER;
         state_ff.last_span      <= 1'b0;
         state_ff.span_remaining <= 7'd0;
         state_ff.column         <= 10'd0;
         state_ff.row_index      <= 10'd0;
         state_ff.error_code     <= ssd_pkg::ST_OK;
      end else if (step_fire) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step_fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_fire) begin
         out_word_ff <= result;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_pixel_valid = out_word_ff.pixel_valid;
   assign rsp_pixel_x     = out_word_ff.pixel_x;
   assign rsp_pixel_row   = out_word_ff.pixel_row;
   assign rsp_pixel_value = out_word_ff.pixel_value;
   assign rsp_row_done    = out_word_ff.row_done;
   assign rsp_image_done  = out_word_ff.image_done;
   assign rsp_status      = out_word_ff.status;

   // an error never clears short of reset
   a_status_sticky: assert property (@(posedge clock) disable iff (reset)
      state_ff.error_code != ssd_pkg::ST_OK |=> state_ff.error_code == $past(state_ff.error_code))
      else $error("decode error code changed after being set");

   // a finished image stays finished
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == ssd_pkg::PH_DONE |=> state_ff.phase == ssd_pkg::PH_DONE)
      else $error("decoder left the done phase");

   // image completion only ever comes with a row completion
   a_image_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_image_done |-> rsp_row_done)
      else $error("image done without row done");

   // a waiting byte is not overwritten
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !step_fire |=> in_valid_ff && $stable(in_data_ff) && $stable(in_end_ff))
      else $error("pending input byte lost");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;

   localparam int PHASES      = 12;
   localparam int PHASE_BYTES = 30;
   localparam int LIMIT       = 300000;

   typedef struct packed {
      logic [7:0] data;
      logic       chunk_end;
   } stream_byte_type;

   typedef enum int {END_COMPLETE, END_BOUNDS, END_PREMATURE} ending_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte = 8'd0;
   logic       req_chunk_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_pixel_valid;
   logic [9:0] rsp_pixel_x;
   logic [9:0] rsp_pixel_row;
   logic [7:0] rsp_pixel_value;
   logic       rsp_row_done;
   logic       rsp_image_done;
   logic [1:0] rsp_status;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_index = ssd_pkg::CSR_IMAGE_WIDTH;
   logic [9:0] csr_wdata = 10'd0;

   // bytes waiting for the driver, decoded words waiting for the dut
   stream_byte_type     stream_q[$];
   ssd_pkg::result_type decoded_q[$];

   // decoder shadow state and geometry
   logic [1:0] dec_phase  = ssd_pkg::PH_HEADER;
   logic       dec_last   = 1'b0;
   logic [6:0] dec_left   = 7'd0;
   logic [9:0] dec_col    = 10'd0;
   logic [9:0] dec_row    = 10'd0;
   logic [1:0] dec_status = ssd_pkg::ST_OK;
   logic [9:0] cfg_width  = ssd_pkg::WIDTH_RESET;
   logic [9:0] cfg_height = ssd_pkg::HEIGHT_RESET;

   int send_idle_pct = 12;
   int recv_idle_pct = 64;
   int gen_rows = 0;
   int mismatches = 0;
   int words_checked = 0;
   int pixels_seen = 0;
   int rows_seen = 0;
   int cycle_count = 0;
   logic image_seen = 1'b0;
   logic [1:0] final_status = ssd_pkg::ST_OK;

   sprite_span_decoder_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_chunk_end   (req_chunk_end),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_valid (rsp_pixel_valid),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_row   (rsp_pixel_row),
      .rsp_pixel_value (rsp_pixel_value),
      .rsp_row_done    (rsp_row_done),
      .rsp_image_done  (rsp_image_done),
      .rsp_status      (rsp_status),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // span closes; a closing last span finishes the row, maybe the image
   function automatic void finish_span(inout ssd_pkg::result_type r);
      dec_phase = ssd_pkg::PH_HEADER;
      if (dec_last) begin
         r.row_done = 1'b1;
         dec_row = dec_row + 10'd1;
         if (dec_row >= cfg_height || dec_row == 10'd0) begin
            r.image_done = 1'b1;
            dec_phase = ssd_pkg::PH_DONE;
         end
      end
   endfunction

   // expected word for one accepted byte
   function automatic ssd_pkg::result_type decode_byte(input logic [7:0] b,
                                                       input logic chunk_end);
      ssd_pkg::result_type r;
      r = '0;
      if (dec_status == ssd_pkg::ST_OK && dec_phase != ssd_pkg::PH_DONE) begin
         unique case (dec_phase)
            ssd_pkg::PH_HEADER: begin
               dec_last  = |(b & ssd_pkg::LAST_MARK);
               dec_left  = b[6:0] & ssd_pkg::LEN_MASK;
               dec_phase = ssd_pkg::PH_XSTART;
            end
            ssd_pkg::PH_XSTART: begin
               dec_col = {2'b00, b};
               if ({2'b00, b} + {3'b000, dec_left} > cfg_width)
                  dec_status = ssd_pkg::ST_BOUNDS;
               else if (dec_left == 7'd0)
                  finish_span(r);
               else
                  dec_phase = ssd_pkg::PH_PIXELS;
            end
            ssd_pkg::PH_PIXELS: begin
               r.pixel_valid = 1'b1;
               r.pixel_x     = dec_col;
               r.pixel_row   = dec_row;
               r.pixel_value = b;
               dec_col  = dec_col + 10'd1;
               dec_left = dec_left - 7'd1;
               if (dec_left == 7'd0)
                  finish_span(r);
            end
            default: ;
         endcase
         if (dec_status == ssd_pkg::ST_OK && chunk_end && dec_phase != ssd_pkg::PH_DONE)
            dec_status = ssd_pkg::ST_PREMATURE;
      end
      r.status = dec_status;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [9:0] want,
                                       input logic [9:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   // stream building
   function automatic void push_byte(input logic [7:0] b, input logic chunk_end);
      stream_byte_type s;
      s.data = b;
      s.chunk_end = chunk_end;
      stream_q.push_back(s);
   endfunction

   function automatic void push_span(input logic is_last, input int x, input int len);
      push_byte({is_last, len[6:0]}, 1'b0);
      push_byte(x[7:0], 1'b0);
      for (int i = 0; i < len; i++)
         push_byte(8'($urandom_range(0, 255)), 1'b0);
      if (is_last)
         gen_rows++;
   endfunction

   // one well-formed row that fits the current width, mostly short spans
   function automatic void push_row();
      int spans, x, cap, len;
      spans = $urandom_range(1, 4);
      for (int s = 0; s < spans; s++) begin
         x   = $urandom_range(0, (cfg_width > 255) ? 255 : cfg_width);
         cap = cfg_width - x;
         if (cap > 127)
            cap = 127;
         if ($urandom_range(0, 7) == 0)
            len = $urandom_range(0, cap);
         else
            len = $urandom_range(0, (cap > 8) ? 8 : cap);
         push_span(s == spans - 1, x, len);
      end
   endfunction

   task automatic wait_drained();
      do @(posedge clock);
      while (stream_q.size() != 0 || req_valid || decoded_q.size() != 0);
   endtask

   // both registers, back to back, while the decoder is idle
   task automatic set_geometry(input logic [9:0] w, input logic [9:0] h);
      csr_valid <= 1'b1;
      csr_index <= ssd_pkg::CSR_IMAGE_WIDTH;
      csr_wdata <= w;
      do @(posedge clock);
      while (!csr_ready);
      cfg_width = w;
      csr_index <= ssd_pkg::CSR_IMAGE_HEIGHT;
      csr_wdata <= h;
      do @(posedge clock);
      while (!csr_ready);
      cfg_height = h;
      csr_valid <= 1'b0;
   endtask

   // byte driver
   always @(posedge clock) begin : drive_bytes
      stream_byte_type s;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            decoded_q.push_back(decode_byte(req_data_byte, req_chunk_end));
         if (!req_valid || req_ready) begin
            if (stream_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               s = stream_q.pop_front();
               req_valid     <= 1'b1;
               req_data_byte <= s.data;
               req_chunk_end <= s.chunk_end;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin : check_words
      ssd_pkg::result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (decoded_q.size() == 0) begin
            mismatches++;
            $display("%0t: result word with no byte pending, expected none, actual pixel %0d",
                     $time, rsp_pixel_valid);
         end else begin
            want = decoded_q.pop_front();
            check_field("pixel_valid", want.pixel_valid, rsp_pixel_valid);
            check_field("pixel_x", want.pixel_x, rsp_pixel_x);
            check_field("pixel_row", want.pixel_row, rsp_pixel_row);
            check_field("pixel_value", want.pixel_value, rsp_pixel_value);
            check_field("row_done", want.row_done, rsp_row_done);
            check_field("image_done", want.image_done, rsp_image_done);
            check_field("status", want.status, rsp_status);
            words_checked++;
            if (want.pixel_valid)
               pixels_seen++;
            if (want.row_done)
               rows_seen++;
            if (want.image_done)
               image_seen = 1'b1;
            final_status = want.status;
         end
      end
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // watchdog
   initial begin : watchdog
      while (cycle_count < LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("sprite_span_decoder_top verification failed");
      $finish;
   end

   initial begin : run_stimulus
      ending_type ending;
      logic [9:0] w;
      logic [9:0] h;
      int first, len, x;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed, at the reset geometry of 64 x 64
      // empty span that is not the last of its row
      push_byte(8'h00, 1'b0);
      push_byte(8'h00, 1'b0);
      // span reaching the right edge exactly, pixel values at both extremes
      push_byte(8'h02, 1'b0);
      push_byte(8'd62, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'hff, 1'b0);
      // empty last span starting at x == width closes row 0
      push_byte(8'h80, 1'b0);
      push_byte(8'd64, 1'b0);
      // row 1: single last span of three
      push_byte(8'h83, 1'b0);
      push_byte(8'h10, 1'b0);
      push_byte(8'h55, 1'b0);
      push_byte(8'haa, 1'b0);
      push_byte(8'h7f, 1'b0);
      // row 2: two spans, a pixel value that looks like a last-span header
      push_byte(8'h01, 1'b0);
      push_byte(8'h3f, 1'b0);
      push_byte(8'h80, 1'b0);
      push_byte(8'h81, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'hc3, 1'b0);
      gen_rows = 3;
      wait_drained();

      // random rows, new geometry each phase, image kept taller than the rows sent
      for (int p = 0; p < PHASES; p++) begin
         if (p == 0)
            w = 10'd1023;
         else if (p == 1)
            w = 10'd1;
         else
            w = 10'($urandom_range(1, 1023));
         h = (p == 0) ? 10'd1023 : 10'($urandom_range(gen_rows + 64, 1023));
         set_geometry(w, h);
         @(negedge clock);
         if (p == PHASES / 3) begin
            send_idle_pct = 64;
            recv_idle_pct = 12;
         end else if (p == 2 * PHASES / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         // longest span, header and x-start both 0xff
         if (p == 0)
            push_span(1'b1, 255, 127);
         while (stream_q.size() < PHASE_BYTES)
            push_row();
         wait_drained();
      end

      // status and completion are sticky, so each run ends one way
      ending = ending_type'($urandom_range(0, 2));
      unique case (ending)
         END_COMPLETE: begin
            // height 1 drops below the rows already done
            h = $urandom_range(0, 1) ? 10'd1 : 10'(gen_rows + 1);
            set_geometry(10'($urandom_range(1, 1023)), h);
            @(negedge clock);
            push_row();
            stream_q[stream_q.size() - 1].chunk_end = 1'b1;
         end
         END_BOUNDS: begin
            // chunk end on the bad x-start must still report the bounds error
            w = 10'($urandom_range(1, 200));
            set_geometry(w, 10'd1023);
            @(negedge clock);
            if ($urandom_range(0, 1))
               push_row();
            len = $urandom_range(1, 127);
            x = $urandom_range((w >= len) ? w - len + 1 : 0, 255);
            push_byte({1'($urandom_range(0, 1)), len[6:0]}, 1'b0);
            push_byte(x[7:0], 1'($urandom_range(0, 1)));
         end
         default: begin
            // chunk end somewhere inside a row
            set_geometry(10'($urandom_range(1, 1023)), 10'd1023);
            @(negedge clock);
            first = stream_q.size();
            push_row();
            stream_q[$urandom_range(first, stream_q.size() - 1)].chunk_end = 1'b1;
         end
      endcase
      // trailing bytes that the decoder must ignore
      for (int i = 0; i < 30; i++)
         push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      wait_drained();
      repeat (8) @(posedge clock);

      $display("checked %0d words over %0d geometry settings: %0d pixel writes, %0d rows",
               words_checked, PHASES + 2, pixels_seen, rows_seen);
      $display("stream ended by %s, image done %0d, final status %0d",
               ending.name(), image_seen, final_status);
      if (mismatches == 0)
         $display("sprite_span_decoder_top verification clean");
      else
         $display("sprite_span_decoder_top verification failed");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/ssd_pkg.sv
hdl/ssd_step.sv
hdl/sprite_span_decoder_top.sv
dv/tb.sv
